/* rtl/core/trp_pkg.sv */
package trp_pkg;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [2:0] SUFFIX_DONE   = 3'd6;
  localparam logic [7:0] FIELD_CNT_MAX = 8'd255;
  localparam logic [4:0] LIMIT_RESET   = 5'd16;

  typedef struct packed {
    logic       done;
    logic       count_ok;
    logic       in_range;
    logic [7:0] total;
  } trp_sum_t;

  function automatic logic [7:0] suffix_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h20;
      3'd1:    c = 8'h72;
      3'd2:    c = 8'h6F;
      3'd3:    c = 8'h77;
      3'd4:    c = 8'h73;
      3'd5:    c = 8'h2E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/trp_parse.sv */
module trp_parse #(
  parameter int MAX_FIELDS  = 16,
  parameter int OFFSET_BITS = 16,
  parameter int COUNT_BITS  = 16,
  parameter int FIW         = 4,
  parameter int CW          = 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   acc,
  input  logic                   has_byte,
  input  logic [7:0]             data_byte,
  input  logic                   end_of_body,
  input  logic [COUNT_BITS-1:0]  wanted_row,
  input  logic                   cfg_wr_en,
  input  logic [4:0]             cfg_wr_data,
  input  logic [FIW-1:0]         rd_idx,
  output logic [OFFSET_BITS-1:0] rd_off,
  output logic [OFFSET_BITS-1:0] rd_len,
  output trp_pkg::trp_sum_t      sum,
  output logic [COUNT_BITS-1:0]  sum_rows,
  output logic [CW-1:0]          sum_nf
);
  import trp_pkg::*;

  typedef enum logic [2:0] {
    PH_FIRST, PH_SEEK, PH_ROWS, PH_NUM, PH_SUFFIX, PH_MATCHED, PH_FAILED
  } phase_t;

  localparam logic [OFFSET_BITS-1:0] OMAX = '1;
  localparam logic [COUNT_BITS-1:0]  CMAX = '1;
  localparam logic [7:0]             MAXF8 = 8'(MAX_FIELDS);

  phase_t                 phase_r, phase_nxt;
  logic                   dash_r, dash_nxt;
  logic                   hasb_r, hasb_nxt;
  logic [COUNT_BITS-1:0]  rows_r, rows_nxt;
  logic [COUNT_BITS-1:0]  tnum_r, tnum_nxt;
  logic                   tdig_r, tdig_nxt;
  logic [2:0]             sidx_r, sidx_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] fstart_r, fstart_nxt;
  logic [7:0]             fcnt_r, fcnt_nxt;
  logic [COUNT_BITS-1:0]  target_r, target_nxt;
  logic [CW-1:0]          scount_r, scount_nxt;
  logic                   open_r, open_nxt;
  logic [4:0]             lim_r;

  logic [OFFSET_BITS-1:0] off_mem [MAX_FIELDS];
  logic [OFFSET_BITS-1:0] len_mem [MAX_FIELDS];
  logic [OFFSET_BITS-1:0] rd_off_r;
  logic [OFFSET_BITS-1:0] rd_len_r;

  logic                   wr_en;
  logic [FIW-1:0]         wr_idx;
  logic [OFFSET_BITS-1:0] wr_off;
  logic [OFFSET_BITS-1:0] wr_len;

  always_comb begin
    logic                   rec;
    logic                   do_close;
    logic                   set_fs;
    logic [7:0]             fc_c;
    logic [CW-1:0]          sc_c;
    logic [OFFSET_BITS-1:0] fs_c;
    logic [OFFSET_BITS-1:0] fs_after;
    logic [7:0]             lim8;
    logic [COUNT_BITS+3:0]  v;

    phase_nxt  = phase_r;
    dash_nxt   = dash_r;
    hasb_nxt   = hasb_r;
    rows_nxt   = rows_r;
    tnum_nxt   = tnum_r;
    tdig_nxt   = tdig_r;
    sidx_nxt   = sidx_r;
    pos_nxt    = pos_r;
    fstart_nxt = fstart_r;
    fcnt_nxt   = fcnt_r;
    scount_nxt = scount_r;
    open_nxt   = open_r;
    target_nxt = open_r ? target_r : wanted_row;
    wr_en      = 1'b0;
    wr_idx     = '0;
    wr_off     = '0;
    wr_len     = '0;
    sum        = '0;
    sum_rows   = '0;
    sum_nf     = '0;

    rec      = (rows_r == target_nxt);
    do_close = 1'b0;
    set_fs   = 1'b0;
    fc_c     = fcnt_r;
    sc_c     = scount_r;
    fs_c     = fstart_r;
    fs_after = (pos_r < OMAX) ? pos_r + 1'b1 : OMAX;
    lim8     = ({3'b000, lim_r} > MAXF8) ? MAXF8 : {3'b000, lim_r};
    v        = ((COUNT_BITS+4)'(tnum_r) << 3) + ((COUNT_BITS+4)'(tnum_r) << 1)
               + (COUNT_BITS+4)'(data_byte[3:0]);

    if (acc) begin
      open_nxt = 1'b1;
      if (has_byte) begin
        pos_nxt = fs_after;
        case (phase_r)
          PH_FIRST: begin
            if (data_byte == CH_LF) begin
              phase_nxt = PH_SEEK;
              dash_nxt  = 1'b1;
              hasb_nxt  = 1'b0;
            end
          end
          PH_SEEK: begin
            if (data_byte == CH_LF) begin
              if (hasb_r && dash_r) phase_nxt = PH_ROWS;
              dash_nxt = 1'b1;
              hasb_nxt = 1'b0;
            end else begin
              hasb_nxt = 1'b1;
              if (data_byte != CH_DASH) dash_nxt = 1'b0;
            end
          end
          PH_ROWS: begin
            if (!hasb_r && data_byte == CH_LF) begin
              phase_nxt = PH_NUM;
            end else begin
              if (!hasb_r) begin
                hasb_nxt = 1'b1;
                if (rec) begin
                  fs_c = pos_r;
                  fc_c = '0;
                  sc_c = '0;
                end
              end
              if (data_byte == CH_LF) begin
                do_close = rec;
                if (rows_r < CMAX) rows_nxt = rows_r + 1'b1;
                hasb_nxt = 1'b0;
              end else if (data_byte == CH_TAB && rec) begin
                do_close = 1'b1;
                set_fs   = 1'b1;
              end
            end
          end
          PH_NUM: begin
            if (data_byte >= CH_ZERO && data_byte <= CH_NINE) begin
              tnum_nxt = (v < (COUNT_BITS+4)'(CMAX)) ? v[COUNT_BITS-1:0] : CMAX;
              tdig_nxt = 1'b1;
            end else if (data_byte == CH_SPACE && !tdig_r) begin
              tdig_nxt = 1'b0;
            end else if (data_byte == CH_SPACE) begin
              sidx_nxt  = 3'd1;
              phase_nxt = PH_SUFFIX;
            end else begin
              phase_nxt = PH_FAILED;
            end
          end
          PH_SUFFIX: begin
            if (sidx_r < SUFFIX_DONE && data_byte == suffix_char(sidx_r)) begin
              sidx_nxt = sidx_r + 1'b1;
              if (sidx_r + 1'b1 == SUFFIX_DONE) phase_nxt = PH_MATCHED;
            end else begin
              phase_nxt = PH_FAILED;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase

        fstart_nxt = set_fs ? fs_after : fs_c;
        fcnt_nxt   = fc_c;
        scount_nxt = sc_c;
        if (do_close) begin
          if (fc_c < lim8 && fc_c == 8'(sc_c)) begin
            wr_en      = 1'b1;
            wr_idx     = FIW'(fc_c);
            wr_off     = fs_c;
            wr_len     = (pos_r >= fs_c) ? pos_r - fs_c : '0;
            scount_nxt = CW'(fc_c + 8'd1);
          end
          if (fc_c < FIELD_CNT_MAX) fcnt_nxt = fc_c + 8'd1;
        end
      end

      if (end_of_body) begin
        sum.done     = 1'b1;
        sum.count_ok = (phase_nxt == PH_MATCHED) && (tnum_nxt != CMAX)
                       && (tnum_nxt == rows_nxt);
        sum.in_range = (target_nxt < rows_nxt);
        sum.total    = fcnt_nxt;
        sum_rows     = rows_nxt;
        sum_nf       = scount_nxt;
        phase_nxt    = PH_FIRST;
        dash_nxt     = 1'b1;
        hasb_nxt     = 1'b0;
        rows_nxt     = '0;
        tnum_nxt     = '0;
        tdig_nxt     = 1'b0;
        sidx_nxt     = '0;
        pos_nxt      = '0;
        fstart_nxt   = '0;
        fcnt_nxt     = '0;
        target_nxt   = '0;
        scount_nxt   = '0;
        open_nxt     = 1'b0;
      end
    end else begin
      target_nxt = target_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FIRST;
      dash_r   <= 1'b1;
      hasb_r   <= 1'b0;
      rows_r   <= '0;
      tnum_r   <= '0;
      tdig_r   <= 1'b0;
      sidx_r   <= '0;
      pos_r    <= '0;
      fstart_r <= '0;
      fcnt_r   <= '0;
      target_r <= '0;
      scount_r <= '0;
      open_r   <= 1'b0;
      lim_r    <= LIMIT_RESET;
    end else begin
      phase_r  <= phase_nxt;
      dash_r   <= dash_nxt;
      hasb_r   <= hasb_nxt;
      rows_r   <= rows_nxt;
      tnum_r   <= tnum_nxt;
      tdig_r   <= tdig_nxt;
      sidx_r   <= sidx_nxt;
      pos_r    <= pos_nxt;
      fstart_r <= fstart_nxt;
      fcnt_r   <= fcnt_nxt;
      target_r <= target_nxt;
      scount_r <= scount_nxt;
      open_r   <= open_nxt;
      if (cfg_wr_en) lim_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      off_mem[wr_idx] <= wr_off;
      len_mem[wr_idx] <= wr_len;
    end
    rd_off_r <= off_mem[rd_idx];
    rd_len_r <= len_mem[rd_idx];
  end

  assign rd_off = rd_off_r;
  assign rd_len = rd_len_r;

endmodule

/* rtl/core/trp_emit.sv */
module trp_emit #(
  parameter int OFFSET_BITS = 16,
  parameter int COUNT_BITS  = 16,
  parameter int FIW         = 4,
  parameter int CW          = 5
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  trp_pkg::trp_sum_t            sum,
  input  logic [COUNT_BITS-1:0]        sum_rows,
  input  logic [CW-1:0]                sum_nf,
  output logic [FIW-1:0]               rd_idx,
  input  logic [OFFSET_BITS-1:0]       rd_off,
  input  logic [OFFSET_BITS-1:0]       rd_len,
  output logic                         busy,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_is_field,
  output logic signed [COUNT_BITS:0]   out_row_count,
  output logic signed [8:0]            out_field_total,
  output logic [FIW-1:0]               out_field_index,
  output logic [OFFSET_BITS-1:0]       out_field_offset,
  output logic [OFFSET_BITS-1:0]       out_field_length,
  output logic                         out_last
);
  import trp_pkg::*;

  logic                        busy_r;
  logic                        out_valid_r;
  logic [CW-1:0]               idx_r;
  logic signed [COUNT_BITS:0]  cnt_r;
  logic signed [8:0]           tot_r;
  logic [CW-1:0]               nf_r;
  logic                        load;
  logic                        last_now;
  logic                        ok_row;
  logic [CW-1:0]               rd_sel;

  logic                        is_field_r;
  logic signed [COUNT_BITS:0]  row_count_r;
  logic signed [8:0]           field_total_r;
  logic [FIW-1:0]              field_index_r;
  logic [OFFSET_BITS-1:0]      field_offset_r;
  logic [OFFSET_BITS-1:0]      field_length_r;
  logic                        last_r;

  assign load     = busy_r && (!out_valid_r || out_ready);
  assign last_now = (idx_r == nf_r);
  // prefetch the entry for the next field word
  assign rd_sel   = load ? idx_r : idx_r - CW'(1);
  assign rd_idx   = FIW'(rd_sel);
  assign ok_row   = sum.count_ok && sum.in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (sum.done) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (load) begin
        idx_r <= idx_r + CW'(1);
        if (last_now) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sum.done) begin
      cnt_r <= sum.count_ok ? {1'b0, sum_rows} : '1;
      tot_r <= ok_row ? {1'b0, sum.total} : '1;
      nf_r  <= ok_row ? sum_nf : '0;
    end
    if (load) begin
      is_field_r     <= (idx_r != '0);
      row_count_r    <= cnt_r;
      field_total_r  <= tot_r;
      last_r         <= last_now;
      if (idx_r == '0) begin
        field_index_r  <= '0;
        field_offset_r <= '0;
        field_length_r <= '0;
      end else begin
        field_index_r  <= FIW'(idx_r - CW'(1));
        field_offset_r <= rd_off;
        field_length_r <= rd_len;
      end
    end
  end

  assign busy             = busy_r;
  assign out_valid        = out_valid_r;
  assign out_is_field     = is_field_r;
  assign out_row_count    = row_count_r;
  assign out_field_total  = field_total_r;
  assign out_field_index  = field_index_r;
  assign out_field_offset = field_offset_r;
  assign out_field_length = field_length_r;
  assign out_last         = last_r;

endmodule

/* rtl/core/tab_table_reply_parser_core.sv */
// table reply parser: scans a reply body one byte per word on the in_ channel,
// finds the dashed rule line, counts rows up to the blank line and checks the
// trailer "<n> rows.", recording tab-separated field positions of in_wanted_row.
// cfg_wr_en/cfg_wr_data set how many field positions are kept (reset 16).
// throughput: one input word per cycle while no results are pending; a word
// without end_of_body produces nothing. a word with end_of_body produces one
// summary word and then up to field_limit field words, the last one flagged.
// output: taking the end word sets the busy register; the summary is then loaded
// into the single out_ channel output register, and the field words follow it
// one at a time through that register. in_ready drops for the whole reply, from
// the cycle after the end word until the last result is loaded; a stall on
// out_ready holds the output register and stretches that window while it lasts.
// reset: synchronous, active low; clears all parser state, drops out_valid
// and sets the field limit to 16. stored field positions are not cleared.
module tab_table_reply_parser_core #(
  parameter int MAX_FIELDS  = 16,
  parameter int OFFSET_BITS = 16,
  parameter int COUNT_BITS  = 16,
  localparam int FIW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1,
  localparam int CW  = $clog2(MAX_FIELDS + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_has_byte,
  input  logic [7:0]                 in_data_byte,
  input  logic                       in_end_of_body,
  input  logic [COUNT_BITS-1:0]      in_wanted_row,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_is_field,
  output logic signed [COUNT_BITS:0] out_row_count,
  output logic signed [8:0]          out_field_total,
  output logic [FIW-1:0]             out_field_index,
  output logic [OFFSET_BITS-1:0]     out_field_offset,
  output logic [OFFSET_BITS-1:0]     out_field_length,
  output logic                       out_last,
  input  logic                       cfg_wr_en,
  input  logic [4:0]                 cfg_wr_data
);
  import trp_pkg::*;

  trp_sum_t               sum;
  logic [COUNT_BITS-1:0]  sum_rows;
  logic [CW-1:0]          sum_nf;
  logic [FIW-1:0]         rd_idx;
  logic [OFFSET_BITS-1:0] rd_off;
  logic [OFFSET_BITS-1:0] rd_len;
  logic                   busy;
  logic                   acc;

  assign in_ready = !busy;
  assign acc      = in_valid && in_ready;

  trp_parse #(
    .MAX_FIELDS (MAX_FIELDS),
    .OFFSET_BITS(OFFSET_BITS),
    .COUNT_BITS (COUNT_BITS),
    .FIW        (FIW),
    .CW         (CW)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .has_byte   (in_has_byte),
    .data_byte  (in_data_byte),
    .end_of_body(in_end_of_body),
    .wanted_row (in_wanted_row),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .rd_idx     (rd_idx),
    .rd_off     (rd_off),
    .rd_len     (rd_len),
    .sum        (sum),
    .sum_rows   (sum_rows),
    .sum_nf     (sum_nf)
  );

  trp_emit #(
    .OFFSET_BITS(OFFSET_BITS),
    .COUNT_BITS (COUNT_BITS),
    .FIW        (FIW),
    .CW         (CW)
  ) u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .sum             (sum),
    .sum_rows        (sum_rows),
    .sum_nf          (sum_nf),
    .rd_idx          (rd_idx),
    .rd_off          (rd_off),
    .rd_len          (rd_len),
    .busy            (busy),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_is_field    (out_is_field),
    .out_row_count   (out_row_count),
    .out_field_total (out_field_total),
    .out_field_index (out_field_index),
    .out_field_offset(out_field_offset),
    .out_field_length(out_field_length),
    .out_last        (out_last)
  );

endmodule

/* rtl/core/trp_chk.sv */
module trp_chk #(
  parameter int COUNT_BITS  = 16,
  parameter int OFFSET_BITS = 16,
  parameter int FIW         = 4
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_end_of_body,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_is_field,
  input logic signed [COUNT_BITS:0] out_row_count,
  input logic signed [8:0]          out_field_total,
  input logic [FIW-1:0]             out_field_index,
  input logic [OFFSET_BITS-1:0]     out_field_offset,
  input logic [OFFSET_BITS-1:0]     out_field_length,
  input logic                       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_is_field)
      && $stable(out_row_count) && $stable(out_field_total)
      && $stable(out_field_index) && $stable(out_field_offset)
      && $stable(out_field_length) && $stable(out_last))
    else $error("result word changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_end_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end_of_body |=> !in_ready)
    else $error("input taken while results of a reply are pending");

  a_field_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_field |-> !out_row_count[COUNT_BITS] && !out_field_total[8])
    else $error("field word from an invalid reply");

  a_bad_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_field && out_field_total[8] |-> out_last)
    else $error("invalid summary not flagged last");

endmodule

bind tab_table_reply_parser_core trp_chk #(
  .COUNT_BITS (COUNT_BITS),
  .OFFSET_BITS(OFFSET_BITS),
  .FIW        (FIW)
) u_trp_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_end_of_body  (in_end_of_body),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_is_field    (out_is_field),
  .out_row_count   (out_row_count),
  .out_field_total (out_field_total),
  .out_field_index (out_field_index),
  .out_field_offset(out_field_offset),
  .out_field_length(out_field_length),
  .out_last        (out_last)
);

/* sim/trp_reply_checker.sv */
module trp_reply_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_has_byte,
  input  logic [7:0]         in_data_byte,
  input  logic               in_end_of_body,
  input  logic [15:0]        in_wanted_row,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_is_field,
  input  logic signed [16:0] out_row_count,
  input  logic signed [8:0]  out_field_total,
  input  logic [3:0]         out_field_index,
  input  logic [15:0]        out_field_offset,
  input  logic [15:0]        out_field_length,
  input  logic               out_last,
  input  logic               cfg_wr_en,
  input  logic [4:0]         cfg_wr_data,
  output int                 fail_count,
  output int                 results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  import trp_pkg::*;

  localparam int          FIELD_SLOTS = 16;
  localparam logic [15:0] SAT16       = 16'hFFFF;
  localparam logic [47:0] ROWS_TAIL   = " rows.";

  typedef enum logic [2:0] {
    SCAN_FIRST, SCAN_SEEK, SCAN_ROWS, SCAN_NUM, SCAN_SUFFIX, SCAN_MATCHED, SCAN_FAILED
  } scan_t;

  typedef struct packed {
    logic               is_field;
    logic signed [16:0] row_count;
    logic signed [8:0]  field_total;
    logic [3:0]         field_index;
    logic [15:0]        field_offset;
    logic [15:0]        field_length;
    logic               last;
  } reply_word_t;

  reply_word_t reply_q[$];

  logic [4:0]  field_cap;
  scan_t       scan;
  logic        dash_line, line_busy, got_digit, body_open;
  logic [15:0] rows_cnt, trailer_val, pos_q, fstart, tgt_row;
  logic [2:0]  sfx_idx;
  logic [7:0]  fcount;
  int          kept;
  logic [15:0] offs[FIELD_SLOTS];
  logic [15:0] lens[FIELD_SLOTS];

  function automatic void clear_body();
    scan        = SCAN_FIRST;
    dash_line   = 1'b1;
    line_busy   = 1'b0;
    rows_cnt    = '0;
    trailer_val = '0;
    got_digit   = 1'b0;
    sfx_idx     = '0;
    pos_q       = '0;
    fstart      = '0;
    fcount      = '0;
    tgt_row     = '0;
    kept        = 0;
    body_open   = 1'b0;
  endfunction

  function automatic void close_field(input logic [15:0] pos);
    int          cap;
    logic [15:0] len;
    cap = (int'(field_cap) > FIELD_SLOTS) ? FIELD_SLOTS : int'(field_cap);
    len = (pos >= fstart) ? pos - fstart : 16'd0;
    if (int'(fcount) < cap && int'(fcount) == kept) begin
      offs[fcount[3:0]] = fstart;
      lens[fcount[3:0]] = len;
      kept = int'(fcount) + 1;
    end
    if (fcount != FIELD_CNT_MAX) fcount++;
  endfunction

  function automatic void check_field(input string name, input logic signed [31:0] want_v,
                                      input logic signed [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : watch_p
    reply_word_t w;
    logic [7:0]  b;
    logic        on_target, count_ok, in_rng;
    int          v, nf;
    if (!rst_n) begin
      field_cap = LIMIT_RESET;
      clear_body();
      reply_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          w = reply_q.pop_front();
          check_field("is_field", w.is_field, out_is_field);
          check_field("row_count", w.row_count, out_row_count);
          check_field("field_total", w.field_total, out_field_total);
          check_field("field_index", w.field_index, out_field_index);
          check_field("field_offset", w.field_offset, out_field_offset);
          check_field("field_length", w.field_length, out_field_length);
          check_field("last", w.last, out_last);
        end
      end
      if (cfg_wr_en) field_cap = cfg_wr_data;
      if (in_valid && in_ready) begin
        if (!body_open) begin
          tgt_row   = in_wanted_row;
          body_open = 1'b1;
        end
        if (in_has_byte) begin
          b = in_data_byte;
          case (scan)
            SCAN_FIRST: begin
              if (b == CH_LF) begin
                scan      = SCAN_SEEK;
                dash_line = 1'b1;
                line_busy = 1'b0;
              end
            end
            SCAN_SEEK: begin
              if (b == CH_LF) begin
                if (line_busy && dash_line) scan = SCAN_ROWS;
                dash_line = 1'b1;
                line_busy = 1'b0;
              end else begin
                line_busy = 1'b1;
                if (b != CH_DASH) dash_line = 1'b0;
              end
            end
            SCAN_ROWS: begin
              on_target = (rows_cnt == tgt_row);
              if (!line_busy && b == CH_LF) begin
                scan = SCAN_NUM;
              end else begin
                if (!line_busy) begin
                  line_busy = 1'b1;
                  if (on_target) begin
                    fstart = pos_q;
                    fcount = '0;
                    kept   = 0;
                  end
                end
                if (b == CH_LF) begin
                  if (on_target) close_field(pos_q);
                  if (rows_cnt != SAT16) rows_cnt++;
                  line_busy = 1'b0;
                end else if (b == CH_TAB && on_target) begin
                  close_field(pos_q);
                  fstart = (pos_q != SAT16) ? pos_q + 16'd1 : SAT16;
                end
              end
            end
            SCAN_NUM: begin
              if (b >= CH_ZERO && b <= CH_NINE) begin
                v = int'(trailer_val) * 10 + (int'(b) - int'(CH_ZERO));
                trailer_val = (v < int'(SAT16)) ? 16'(v) : SAT16;
                got_digit = 1'b1;
              end else if (b == CH_SPACE && !got_digit) begin
                // leading space
              end else if (b == CH_SPACE) begin
                sfx_idx = 3'd1;
                scan    = SCAN_SUFFIX;
              end else begin
                scan = SCAN_FAILED;
              end
            end
            SCAN_SUFFIX: begin
              if (b == ROWS_TAIL[47 - 8 * sfx_idx -: 8]) begin
                sfx_idx++;
                if (sfx_idx == SUFFIX_DONE) scan = SCAN_MATCHED;
              end else begin
                scan = SCAN_FAILED;
              end
            end
            default: ;
          endcase
          if (pos_q != SAT16) pos_q++;
        end
        if (in_end_of_body) begin
          count_ok = (scan == SCAN_MATCHED) && (trailer_val != SAT16) &&
                     (trailer_val == rows_cnt);
          in_rng   = count_ok && (tgt_row < rows_cnt);
          nf       = in_rng ? kept : 0;
          w.is_field     = 1'b0;
          w.row_count    = count_ok ? $signed({1'b0, rows_cnt}) : -17'sd1;
          w.field_total  = in_rng ? $signed({1'b0, fcount}) : -9'sd1;
          w.field_index  = '0;
          w.field_offset = '0;
          w.field_length = '0;
          w.last         = (nf == 0);
          reply_q.push_back(w);
          for (int i = 0; i < nf; i++) begin
            w.is_field     = 1'b1;
            w.field_index  = 4'(i);
            w.field_offset = offs[i];
            w.field_length = lens[i];
            w.last         = (i == nf - 1);
            reply_q.push_back(w);
          end
          clear_body();
        end
      end
    end
    results_due = reply_q.size();
  end

endmodule

/* sim/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import trp_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_has_byte;
  logic [7:0]         in_data_byte;
  logic               in_end_of_body;
  logic [15:0]        in_wanted_row;
  logic               out_valid;
  logic               out_ready;
  logic               out_is_field;
  logic signed [16:0] out_row_count;
  logic signed [8:0]  out_field_total;
  logic [3:0]         out_field_index;
  logic [15:0]        out_field_offset;
  logic [15:0]        out_field_length;
  logic               out_last;
  logic               cfg_wr_en;
  logic [4:0]         cfg_wr_data;
  int                 fail_count;
  int                 results_due;

  int          tx_idle = 6;
  int          rx_idle = 51;
  int          item_count = 0;
  logic [7:0]  body[$];

  tab_table_reply_parser_core dut (.*);

  trp_reply_checker chk (.*);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= rx_idle);

  function automatic void push_str(input string s);
    for (int i = 0; i < s.len(); i++) body.push_back(s[i]);
  endfunction

  function automatic logic [7:0] field_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == CH_LF || b == CH_TAB);
    return b;
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(5))
      0:       return CH_LF;
      1:       return CH_DASH;
      2:       return CH_TAB;
      3:       return CH_SPACE;
      4:       return 8'(CH_ZERO + $urandom_range(9));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void build_table(input int hdr_len, input int rows, input int tabs_lo,
                                      input int tabs_hi, input int claim);
    int tabs, mark;
    body.delete();
    repeat (hdr_len) body.push_back(field_byte());
    body.push_back(CH_LF);
    repeat ($urandom_range(1)) begin
      body.push_back(8'($urandom_range(8'h5A, 8'h41)));
      repeat ($urandom_range(3)) body.push_back(field_byte());
      body.push_back(CH_LF);
    end
    if ($urandom_range(3) == 0) body.push_back(CH_LF);
    repeat ($urandom_range(5, 1)) body.push_back(CH_DASH);
    body.push_back(CH_LF);
    for (int r = 0; r < rows; r++) begin
      tabs = $urandom_range(tabs_hi, tabs_lo);
      mark = body.size();
      for (int f = 0; f <= tabs; f++) begin
        if (f > 0) body.push_back(CH_TAB);
        repeat ($urandom_range(3)) body.push_back(field_byte());
      end
      if (body.size() == mark) body.push_back(field_byte());
      body.push_back(CH_LF);
    end
    body.push_back(CH_LF);
    repeat ($urandom_range(2)) body.push_back(CH_SPACE);
    push_str($sformatf("%0d rows.", claim));
    if ($urandom_range(3) == 0) repeat ($urandom_range(4, 1)) body.push_back(noise_byte());
  endfunction

  task automatic send_word(input logic has, input logic [7:0] b, input logic eob,
                           input logic [15:0] row);
    while ($urandom_range(99) < tx_idle) begin
      in_valid     <= 1'b0;
      in_data_byte <= 8'($urandom);
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_has_byte    <= has;
    in_data_byte   <= b;
    in_end_of_body <= eob;
    in_wanted_row  <= row;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    item_count++;
  endtask

  task automatic send_body(input logic [15:0] row);
    bit first, split_end;
    int n;
    n         = body.size();
    first     = 1'b1;
    split_end = (n == 0) || ($urandom_range(3) == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0) begin
        send_word(1'b0, 8'($urandom), 1'b0, first ? row : 16'($urandom));
        first = 1'b0;
      end
      send_word(1'b1, body[i], !split_end && (i == n - 1), first ? row : 16'($urandom));
      first = 1'b0;
    end
    if (split_end) send_word(1'b0, 8'($urandom), 1'b1, first ? row : 16'($urandom));
  endtask

  task automatic run_text(input string s, input logic [15:0] row);
    body.delete();
    push_str(s);
    send_body(row);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_due != 0);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_limit(input logic [4:0] lim);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= lim;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_random(input int tx, input int rx, input int quota);
    int          kind, rows, claim, stop_at;
    logic [15:0] row;
    tx_idle = tx;
    rx_idle = rx;
    stop_at = item_count + quota;
    while (item_count < stop_at) begin
      if ($urandom_range(3) == 0) begin
        drain();
        case ($urandom_range(4))
          0:       set_limit(5'd0);
          1:       set_limit(5'd1);
          2:       set_limit(LIMIT_RESET);
          3:       set_limit(5'd31);
          default: set_limit(5'($urandom));
        endcase
      end
      kind  = $urandom_range(99);
      rows  = $urandom_range(4);
      claim = rows;
      if (kind >= 65 && kind < 75) begin
        case ($urandom_range(3))
          0:       claim = rows + 1;
          1:       claim = 65535;
          2:       claim = 99999;
          default: claim = $urandom_range(9);
        endcase
      end
      build_table($urandom_range(4), rows, 0, ($urandom_range(7) == 0) ? 20 : 4, claim);
      if (kind >= 75 && kind < 85) begin
        claim = $urandom_range(body.size() - 1);
        while (body.size() > claim) void'(body.pop_back());
      end else if (kind >= 85 && kind < 93) begin
        body[$urandom_range(body.size() - 1)] = noise_byte();
      end else if (kind >= 93) begin
        body.delete();
        repeat ($urandom_range(24)) body.push_back(noise_byte());
      end
      row = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(rows));
      send_body(row);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_has_byte    = 1'b0;
    in_data_byte   = '0;
    in_end_of_body = 1'b0;
    in_wanted_row  = '0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty body
    body.delete();
    send_body(16'd0);

    // zero byte, high byte and empty fields, row picked at each end and out of range
    body.delete();
    push_str("id\tname\n--\n");
    body.push_back(8'h00);
    push_str("\t");
    body.push_back(8'hFF);
    push_str("\t\tz\nq\n\n  2 rows.tail");
    send_body(16'd0);
    send_body(16'd1);
    send_body(16'd2);
    send_body(16'hFFFF);

    run_text("h\n-\nr\n\n1 row", 16'd0);
    run_text("h\n---", 16'd0);
    run_text("h\n-\nr\n\n1\n rows.", 16'd0);
    run_text("h\n-\nr\n\n1x rows.", 16'd0);
    run_text("h\n-\nr\n\n 65535 rows.", 16'd0);
    run_text("h\n-\nr\n\n99999 rows.", 16'd0);
    run_text("h\n-\nr\n\n2 rows.", 16'd0);
    run_text("---\nx\n\n-x\n--\na\tb\n\n1 rows.", 16'd0);
    run_text("h\n-\nr\n\n rows.", 16'd0);
    run_text("-\n-\n\n0 rows.", 16'd0);

    drain();
    set_limit(5'd0);
    build_table(1, 2, 3, 6, 2);
    send_body(16'd0);
    drain();
    set_limit(5'd31);
    build_table(1, 1, 20, 20, 1);
    send_body(16'd0);
    drain();
    set_limit(5'd1);
    build_table(1, 3, 2, 3, 3);
    send_body(16'd1);
    drain();
    set_limit(LIMIT_RESET);

    run_random(6, 51, 40);
    run_random(51, 6, 40);
    run_random(0, 0, 40);

    drain();
    if (fail_count == 0 && results_due == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/trp_pkg.sv
rtl/core/trp_parse.sv
rtl/core/trp_emit.sv
rtl/core/tab_table_reply_parser_core.sv
rtl/core/trp_chk.sv
sim/trp_reply_checker.sv
sim/tb_top.sv
